[hdl/srs_pkg.sv]
// Shared types and constants for the synthesiser register serialiser.
package srs_pkg;

  localparam int unsigned WORD_BITS  = 20;
  localparam int unsigned INDEX_BITS = 2;
  localparam int unsigned FREQ_BITS  = 14;
  localparam int unsigned POWER_BITS = 8;

  localparam logic [WORD_BITS-1:0] REFERENCE_RST  = 20'd400;
  localparam logic [WORD_BITS-1:0] HIGH_POWER_RST = 20'd20413;
  localparam logic [WORD_BITS-1:0] LOW_POWER_RST  = 20'd16509;

  localparam logic [INDEX_BITS-1:0] CFG_REFERENCE  = 2'd0;
  localparam logic [INDEX_BITS-1:0] CFG_HIGH_POWER = 2'd1;
  localparam logic [INDEX_BITS-1:0] CFG_LOW_POWER  = 2'd2;

  localparam logic [7:0] REG_REFERENCE = 8'd0;
  localparam logic [7:0] REG_DIVIDER   = 8'd1;
  localparam logic [7:0] REG_POWER     = 8'd7;

  typedef enum logic {
    ST_IDLE,
    ST_PEND
  } srs_state_t;

  typedef struct packed {
    logic load;
    logic fin;
  } srs_ctl_t;

endpackage

[hdl/srs_cfg.sv]
// Configuration register file holding the three data words.
module srs_cfg
  import srs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]  cfg_data,
  output logic [WORD_BITS-1:0]  reference_word,
  output logic [WORD_BITS-1:0]  high_power_word,
  output logic [WORD_BITS-1:0]  low_power_word
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_word  <= REFERENCE_RST;
      high_power_word <= HIGH_POWER_RST;
      low_power_word  <= LOW_POWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REFERENCE:  reference_word  <= cfg_data;
        CFG_HIGH_POWER: high_power_word <= cfg_data;
        CFG_LOW_POWER:  low_power_word  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/srs_shifter.sv]
// Frame shift register that sends one bit per cycle into the output register while that register is not stalled.
module srs_shifter
  import srs_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 4,
  parameter int unsigned DATA_BITS    = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srs_ctl_t                ctl,
  input  logic [ADDRESS_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0]    word,
  output logic                    busy,
  output logic                    bit_valid,
  input  logic                    bit_stall,
  output logic                    data_bit,
  output logic                    frame_start,
  output logic                    frame_end,
  output logic                    last
);

  localparam int unsigned FRAME_BITS = ADDRESS_BITS + 1 + DATA_BITS;
  localparam int unsigned CW         = $clog2(FRAME_BITS + 1);

  logic [FRAME_BITS-1:0] sh;
  logic [CW-1:0]         cnt;
  logic                  fin;
  logic                  advance;

  assign busy    = (cnt != '0);
  assign advance = busy && (!bit_valid || !bit_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      bit_valid <= 1'b0;
    end else begin
      if (ctl.load && !busy) begin
        cnt <= CW'(FRAME_BITS);
      end else if (advance) begin
        cnt <= cnt - CW'(1);
      end
      if (advance) begin
        bit_valid <= 1'b1;
      end else if (!bit_stall) begin
        bit_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && !busy) begin
      sh  <= {word, 1'b1, addr};
      fin <= ctl.fin;
    end else if (advance) begin
      sh <= sh >> 1;
    end
    if (advance) begin
      data_bit    <= sh[0];
      frame_start <= (cnt == CW'(FRAME_BITS));
      frame_end   <= (cnt == CW'(1));
      last        <= (cnt == CW'(1)) && fin;
    end
  end

endmodule

[hdl/synth_register_serializer.sv]
// Top level of the synthesiser register serialiser: command sequencing and frame set-up.
//
//   channel | signals                                    | handshake
//   cmd     | op, frequency_mhz, power_level             | cmd_valid / cmd_stall
//   bit     | data_bit, frame_start, frame_end, last     | bit_valid / bit_stall
//   cfg     | cfg_index, cfg_data                        | cfg_valid / cfg_ready
//
// A frame is ADDRESS_BITS + 1 + DATA_BITS bits, one bit per cycle from the frame shift register
// while the bit channel does not stall. Each frame is loaded into the shift register before its
// bits are sent; a power request sends one frame and a frequency request sends two.
// The next request is taken once the last frame has left the shift register.
// Reset is synchronous and restores the three configuration words.
// A stall on the bit channel while a bit is valid holds the output register and pauses the shift register.
module synth_register_serializer
  import srs_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 4,
  parameter int unsigned DATA_BITS    = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic                  op,
  input  logic [FREQ_BITS-1:0]  frequency_mhz,
  input  logic [POWER_BITS-1:0] power_level,
  output logic                  bit_valid,
  input  logic                  bit_stall,
  output logic                  data_bit,
  output logic                  frame_start,
  output logic                  frame_end,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]  cfg_data
);

  logic [WORD_BITS-1:0]    reference_word;
  logic [WORD_BITS-1:0]    high_power_word;
  logic [WORD_BITS-1:0]    low_power_word;
  srs_state_t              state;
  srs_state_t              state_next;
  srs_ctl_t                ctl;
  logic [ADDRESS_BITS-1:0] addr;
  logic [DATA_BITS-1:0]    word;
  logic                    busy;
  logic [DATA_BITS-1:0]    pend_word;
  logic [18:0]             scaled;
  logic [WORD_BITS-1:0]    divider_word;
  logic                    accept;

  srs_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .reference_word  (reference_word),
    .high_power_word (high_power_word),
    .low_power_word  (low_power_word)
  );

  // The frequency times 25 is split into a 64-step prescaler count and a remainder.
  assign scaled       = {1'b0, frequency_mhz, 4'b0} + {2'b0, frequency_mhz, 3'b0}
                        + {5'b0, frequency_mhz};
  assign divider_word = {scaled[18:6], 1'b0, scaled[5:0]};
  assign accept       = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_word <= DATA_BITS'(divider_word);
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    ctl.load   = 1'b0;
    ctl.fin    = 1'b1;
    addr       = REG_DIVIDER[ADDRESS_BITS-1:0];
    word       = pend_word;
    case (state)
      ST_IDLE: begin
        cmd_stall = busy;
        if (op) begin
          addr = REG_POWER[ADDRESS_BITS-1:0];
          word = (power_level[POWER_BITS-1:1] != '0) ? DATA_BITS'(high_power_word)
                                                      : DATA_BITS'(low_power_word);
        end else begin
          addr    = REG_REFERENCE[ADDRESS_BITS-1:0];
          word    = DATA_BITS'(reference_word);
          ctl.fin = 1'b0;
        end
        if (cmd_valid && !busy) begin
          ctl.load = 1'b1;
          if (!op) begin
            state_next = ST_PEND;
          end
        end
      end
      ST_PEND: begin
        if (!busy) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  srs_shifter #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .DATA_BITS    (DATA_BITS)
  ) u_shifter (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .addr        (addr),
    .word        (word),
    .busy        (busy),
    .bit_valid   (bit_valid),
    .bit_stall   (bit_stall),
    .data_bit    (data_bit),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .last        (last)
  );

endmodule

[hdl/srs_checker.sv]
// Port-level checks for the synthesiser register serialiser, bound to the top level.
module srs_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_stall,
  input logic bit_valid,
  input logic bit_stall,
  input logic data_bit,
  input logic frame_start,
  input logic frame_end,
  input logic last
);

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    bit_valid && last |-> frame_end)
    else $error("Last bit of a request does not end a frame.");

  a_start_not_end: assert property (@(posedge clk) disable iff (rst)
    bit_valid && frame_start |-> !frame_end)
    else $error("A frame starts and ends on the same bit.");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("A new request was taken straight after another.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    bit_valid && bit_stall |=> bit_valid && $stable(data_bit) && $stable(frame_start)
      && $stable(frame_end) && $stable(last))
    else $error("Stalled output bit changed.");

endmodule

bind synth_register_serializer srs_checker u_srs_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_valid),
  .cmd_stall   (cmd_stall),
  .bit_valid   (bit_valid),
  .bit_stall   (bit_stall),
  .data_bit    (data_bit),
  .frame_start (frame_start),
  .frame_end   (frame_end),
  .last        (last)
);
